// ===== rtl/opis_pkg.sv =====
// Shared types and constants for the OLED power and init sequencer.
// Holds the panel state enum, the job descriptor passed front to back,
// the init burst table and the port bit positions. No dependencies.
package opis_pkg;

  // Panel power states
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_APPLY   = 3'd1,
    ST_RESET   = 3'd2,
    ST_INITREG = 3'd3,
    ST_INITUI  = 3'd4,
    ST_ON      = 3'd5,
    ST_GOOFF   = 3'd6,
    ST_OFF     = 3'd7
  } panel_state_t;

  // Request kinds on the input tuser
  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON_REQ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OFF_REQ  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DISPLAY  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CONTRAST = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_DELAY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFF_DELAY   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONTRAST    = 2'd2;

  localparam logic [15:0] START_DELAY_RST = 16'd10;
  localparam logic [15:0] OFF_DELAY_RST   = 16'd100;
  localparam logic [7:0]  CONTRAST_RST    = 8'd240;

  // Panel command bytes
  localparam logic [7:0] CMD_DISPLAY_OFF  = 8'hAE;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;
  localparam logic [7:0] CMD_SET_CONTRAST = 8'h81;

  // Init burst
  localparam int unsigned BURST_LEN     = 27;
  localparam int unsigned CONTRAST_SLOT = 20;
  localparam int unsigned SEQ_W         = $clog2(BURST_LEN);

  // Kinds of work handed to the back end
  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,  // one status result, no byte
    JOB_BYTE   = 2'd1,  // one command byte
    JOB_PAIR   = 2'd2,  // set-contrast command then its value
    JOB_BURST  = 2'd3   // full init burst
  } job_kind_t;

  typedef struct packed {
    job_kind_t    kind;
    logic [7:0]   data;       // byte, contrast value or burst contrast
    logic         pulse;
    logic         accepted;
    logic         rst_level;
    panel_state_t state;      // state after the request
  } job_t;

  // Job queue depth
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Stream payload layout
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_RST_LVL  = 8;
  localparam int unsigned OUT_PULSE    = 9;
  localparam int unsigned OUT_STATE_LO = 10;
  localparam int unsigned OUT_IS_ON    = 13;
  localparam int unsigned OUT_IS_OFF   = 14;
  localparam int unsigned OUT_ACCEPTED = 15;
  localparam int unsigned OUT_AWAKE    = 16;

  // Init burst byte at a position; the contrast slot takes the configured value
  function automatic logic [7:0] burst_byte(input logic [SEQ_W-1:0] idx,
                                            input logic [7:0] contrast);
    logic [7:0] b;
    case (idx)
      5'd0:  b = 8'hAE;
      5'd1:  b = 8'hD5;
      5'd2:  b = 8'hC1;
      5'd3:  b = 8'hA8;
      5'd4:  b = 8'h1F;
      5'd5:  b = 8'hAD;
      5'd6:  b = 8'h00;
      5'd7:  b = 8'h20;
      5'd8:  b = 8'h02;
      5'd9:  b = 8'hD3;
      5'd10: b = 8'h00;
      5'd11: b = 8'h40;
      5'd12: b = 8'h8D;
      5'd13: b = 8'h8D;
      5'd14: b = 8'h14;
      5'd15: b = 8'hA0;
      5'd16: b = 8'hC8;
      5'd17: b = 8'hDA;
      5'd18: b = 8'h12;
      5'd19: b = CMD_SET_CONTRAST;
      5'd20: b = contrast;
      5'd21: b = 8'hD9;
      5'd22: b = 8'h22;
      5'd23: b = 8'hDB;
      5'd24: b = 8'h00;
      5'd25: b = 8'hA4;
      5'd26: b = 8'hA6;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/opis_front.sv =====
// Front end: accepts requests, runs the panel state machine and the delay
// timers, and turns each request into one job descriptor. Uses opis_pkg.
module opis_front #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [2:0]           mode,
  input  logic [31:0]          time_now,
  input  logic [7:0]           value,
  input  logic [15:0]          start_delay,
  input  logic [15:0]          off_delay,
  input  logic [7:0]           contrast,
  output opis_pkg::job_t       job
);
  import opis_pkg::*;

  panel_state_t         st_r, st_nxt;
  logic [TIME_BITS-1:0] ts_r, ts_nxt;
  logic                 rp_r, rp_nxt;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] diff;
  logic                 start_done;
  logic                 off_done;

  // Elapsed time, modulo the timer width
  assign now        = TIME_BITS'(time_now);
  assign diff       = now - ts_r;
  assign start_done = diff > TIME_BITS'(start_delay);
  assign off_done   = diff > TIME_BITS'(off_delay);

  // Next state, timestamp and reset pin
  always_comb begin
    st_nxt = st_r;
    ts_nxt = ts_r;
    rp_nxt = rp_r;
    unique case (mode)
      MODE_TICK: begin
        unique case (st_r)
          ST_APPLY: begin
            ts_nxt = now;
            rp_nxt = 1'b1;
            st_nxt = ST_RESET;
          end
          ST_RESET: begin
            if (start_done) begin
              rp_nxt = 1'b1;
              st_nxt = ST_INITREG;
            end
          end
          ST_INITREG: st_nxt = ST_INITUI;
          ST_INITUI:  st_nxt = ST_ON;
          ST_GOOFF: begin
            rp_nxt = 1'b0;
            ts_nxt = now;
            st_nxt = ST_OFF;
          end
          ST_OFF: begin
            if (off_done) st_nxt = ST_IDLE;
          end
          default: st_nxt = st_r;
        endcase
      end
      MODE_ON_REQ: begin
        if (st_r == ST_IDLE) st_nxt = ST_APPLY;
      end
      MODE_OFF_REQ: st_nxt = ST_GOOFF;
      default: st_nxt = st_r;
    endcase
  end

  // Job descriptor for the back end
  always_comb begin
    job           = '0;
    job.kind      = JOB_STATUS;
    job.rst_level = rp_nxt;
    job.state     = st_nxt;
    unique case (mode)
      MODE_TICK: begin
        if (st_r == ST_RESET && start_done) job.pulse = 1'b1;
        if (st_r == ST_INITREG) begin
          job.kind = JOB_BURST;
          job.data = contrast;
        end
        if (st_r == ST_GOOFF) begin
          job.kind = JOB_BYTE;
          job.data = CMD_DISPLAY_OFF;
        end
      end
      MODE_ON_REQ:  job.accepted = (st_r == ST_IDLE);
      MODE_DISPLAY: begin
        job.kind = JOB_BYTE;
        job.data = value[0] ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF;
      end
      MODE_CONTRAST: begin
        job.kind = JOB_PAIR;
        job.data = value;
      end
      default: job.kind = JOB_STATUS;
    endcase
  end

  // Commit on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ts_r <= '0;
      rp_r <= 1'b0;
    end else if (fire) begin
      st_r <= st_nxt;
      ts_r <= ts_nxt;
      rp_r <= rp_nxt;
    end
  end

endmodule

// ===== rtl/opis_queue.sv =====
// Short job queue between front and back end.
// Register based ring of job descriptors. Uses opis_pkg.
module opis_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  opis_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output opis_pkg::job_t rd_data,
  output logic           nonempty
);
  import opis_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en)      cnt_r <= cnt_r + 1'b1;
      else if (!wr_en && rd_en) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/opis_back.sv =====
// Back end: expands each job into result items, one per cycle while
// out_tready does not stall it, into a registered output stage. Uses opis_pkg.
module opis_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_nonempty,
  input  opis_pkg::job_t                       q_data,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [opis_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [0:0]                           out_tuser,
  output logic                                 out_tlast
);
  import opis_pkg::*;

  job_t                   job_r;
  logic                   job_vld_r;
  logic [SEQ_W-1:0]       cnt_r;
  logic                   advance;
  logic                   res_last;
  logic                   res_bv;
  logic [7:0]             res_byte;
  logic [OUT_TDATA_W-1:0] res_data;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;
  logic                   out_last_r;

  assign advance = job_vld_r && (!out_vld_r || out_tready);
  assign q_pop   = q_nonempty && (!job_vld_r || (advance && res_last));

  // Decode the current result of the job
  always_comb begin
    res_bv   = 1'b1;
    res_byte = job_r.data;
    res_last = 1'b1;
    unique case (job_r.kind)
      JOB_STATUS: begin
        res_bv   = 1'b0;
        res_byte = 8'h00;
      end
      JOB_BYTE: res_byte = job_r.data;
      JOB_PAIR: begin
        res_byte = (cnt_r == '0) ? CMD_SET_CONTRAST : job_r.data;
        res_last = (cnt_r == SEQ_W'(1));
      end
      JOB_BURST: begin
        res_byte = burst_byte(cnt_r, job_r.data);
        res_last = (cnt_r == SEQ_W'(BURST_LEN - 1));
      end
      default: res_bv = 1'b0;
    endcase
  end

  // Pack the status fields
  always_comb begin
    res_data                                = '0;
    res_data[7:0]                           = res_byte;
    res_data[OUT_RST_LVL]                   = job_r.rst_level;
    res_data[OUT_PULSE]                     = job_r.pulse;
    res_data[OUT_STATE_LO +: 3]             = job_r.state;
    res_data[OUT_IS_ON]                     = (job_r.state == ST_ON);
    res_data[OUT_IS_OFF]                    = (job_r.state == ST_IDLE);
    res_data[OUT_ACCEPTED]                  = job_r.accepted;
    res_data[OUT_AWAKE]                     = (job_r.state != ST_IDLE);
  end

  // Hold the active job and step through its results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else if (q_pop) begin
      job_vld_r <= 1'b1;
      cnt_r     <= '0;
    end else if (advance && res_last) begin
      job_vld_r <= 1'b0;
    end else if (advance) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_data;
      out_user_r <= res_bv;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;
  assign out_tlast    = out_last_r;

endmodule

// ===== rtl/oled_power_init_sequencer.sv =====
// Top level of the OLED power and init sequencer.
// Instantiates opis_front, opis_queue and opis_back; uses opis_pkg.
//
// Usage:
//   Input stream in_*: one request per item. in_tuser carries the request
//   kind (tick, panel on, panel off, display on/off, set contrast), in_tdata
//   the current millisecond time and a value byte. Ticks drive the power
//   state machine and its delay timers.
//   Output stream out_*: one or more results per request, tlast on the
//   final one. out_tuser flags a command byte; out_tdata holds the byte,
//   reset line level and pulse request, and the panel state flags.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (start delay,
//   off delay, init contrast); users write only while idle, the block does not check it.
// Timing:
//   The front takes one request per cycle while the two-entry job queue
//   has room. The back emits one result per cycle while out_tready does
//   not stall it; the init burst has 27 results and every other request
//   one or two. With the back end idle, a request passes the queue entry,
//   the job register and the output register before out_tvalid rises.
// Reset: state idle, reset line low, timestamp zero, registers to defaults.
// Stall: out_tready low holds the output register; the back end stops and
//   the queue fills, after which in_tready drops.
module oled_power_init_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Request stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [opis_pkg::IN_TDATA_W-1:0]        in_tdata,  // time_now[31:0], value[39:32]
  input  logic [2:0]                             in_tuser,  // mode[2:0]
  // Result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // cmd_byte[7:0], reset_level[8], reset_pulse[9], panel_state[12:10],
  // panel_is_on[13], panel_is_off[14], request_accepted[15], keep_awake[16]
  output logic [opis_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [0:0]                             out_tuser, // byte_valid[0]
  output logic                                   out_tlast,
  // Configuration writes
  input  logic                                   cfg_we,
  input  logic [opis_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [opis_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import opis_pkg::*;

  logic [15:0] start_delay_r;
  logic [15:0] off_delay_r;
  logic [7:0]  contrast_r;
  logic        fire;
  logic        q_full;
  logic        q_nonempty;
  logic        q_pop;
  job_t        front_job;
  job_t        q_job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r <= START_DELAY_RST;
      off_delay_r   <= OFF_DELAY_RST;
      contrast_r    <= CONTRAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_DELAY: start_delay_r <= cfg_wdata;
        CFG_OFF_DELAY:   off_delay_r   <= cfg_wdata;
        CFG_CONTRAST:    contrast_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  opis_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .mode        (in_tuser),
    .time_now    (in_tdata[31:0]),
    .value       (in_tdata[39:32]),
    .start_delay (start_delay_r),
    .off_delay   (off_delay_r),
    .contrast    (contrast_r),
    .job         (front_job)
  );

  opis_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fire),
    .wr_data  (front_job),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_job),
    .nonempty (q_nonempty)
  );

  opis_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_data     (q_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/opis_checker.sv =====
// Port-level checks for the OLED power and init sequencer.
// Bound to oled_power_init_sequencer; uses opis_pkg.
module opis_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [opis_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [0:0]                         out_tuser,
  input logic                               out_tlast
);
  import opis_pkg::*;

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // On flag follows the reported state
  a_on_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_IS_ON] ==
                   (out_tdata[OUT_STATE_LO +: 3] == 3'(ST_ON)))
    else $error("panel_is_on disagrees with panel_state");

  // Keep-awake is the inverse of off
  a_awake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_AWAKE] != out_tdata[OUT_IS_OFF])
    else $error("keep_awake disagrees with panel_is_off");

  // No byte flagged means a zero byte
  a_quiet_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'h00)
    else $error("nonzero byte without byte_valid");

  // Reset pulse comes with the line high, as a single status result
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_PULSE] |-> out_tdata[OUT_RST_LVL] && out_tlast)
    else $error("reset pulse without reset line high");

endmodule

bind oled_power_init_sequencer opis_checker u_opis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for oled_power_init_sequencer: drives requests on the
// input stream, predicts every result from its own panel power model and checks
// the output stream. Depends on opis_pkg and the RTL top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import opis_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_REQUESTS = 70;

  // Init burst, byte i at bits [8*i +: 8]; the contrast slot is patched in
  localparam logic [8*BURST_LEN-1:0] INIT_SEQ = {
    8'hA6, 8'hA4, 8'h00, 8'hDB, 8'h22, 8'hD9, 8'h00, 8'h81, 8'h12,
    8'hDA, 8'hC8, 8'hA0, 8'h14, 8'h8D, 8'h8D, 8'h40, 8'h00, 8'hD3,
    8'h02, 8'h20, 8'h00, 8'hAD, 8'h1F, 8'hA8, 8'hC1, 8'hD5, 8'hAE
  };

  typedef struct packed {
    logic         byte_valid;
    logic [7:0]   cmd;
    logic         rst_level;
    logic         pulse;
    panel_state_t state;
    logic         is_on;
    logic         is_off;
    logic         accepted;
    logic         awake;
    logic         last;
  } panel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Panel model state and its copy of the registers
  panel_state_t panel = ST_IDLE;
  logic [31:0] stamp_ms = '0;
  logic rst_line = 1'b0;
  logic [15:0] start_delay_ms = START_DELAY_RST;
  logic [15:0] off_delay_ms = OFF_DELAY_RST;
  logic [7:0] contrast_cfg = CONTRAST_RST;

  panel_result_t cmd_expect[$];
  panel_result_t want;
  int errors = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit pace_gaps = 1'b1;
  int requests_sent = 0;
  logic [31:0] ms_now = '0;

  oled_power_init_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // time_now[31:0], value[39:32]
    .in_tuser  (in_tuser),   // mode[2:0]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // cmd_byte, reset_level, reset_pulse, panel_state, flags
    .out_tuser (out_tuser),  // byte_valid[0]
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Queue one expected result, flags taken from the model state
  task automatic push_result(input logic valid, input logic [7:0] cmd, input logic pulse,
                             input logic accepted, input logic last);
    panel_result_t r;
    r.byte_valid = valid;
    r.cmd        = valid ? cmd : 8'h00;
    r.rst_level  = rst_line;
    r.pulse      = pulse;
    r.state      = panel;
    r.is_on      = (panel == ST_ON);
    r.is_off     = (panel == ST_IDLE);
    r.accepted   = accepted;
    r.awake      = (panel != ST_IDLE);
    r.last       = last;
    cmd_expect.push_back(r);
  endtask

  // Advance the panel model by one request and queue what it emits
  task automatic predict_panel(input logic [2:0] mode, input logic [31:0] now,
                               input logic [7:0] val);
    logic [31:0] elapsed;
    logic [7:0] b;
    logic pulse;
    elapsed = now - stamp_ms;
    pulse = 1'b0;
    case (mode)
      MODE_TICK: begin
        case (panel)
          ST_APPLY: begin
            stamp_ms = now;
            rst_line = 1'b1;
            panel = ST_RESET;
            push_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
          end
          ST_RESET: begin
            if (elapsed > {16'd0, start_delay_ms}) begin
              rst_line = 1'b1;
              pulse = 1'b1;
              panel = ST_INITREG;
            end
            push_result(1'b0, 8'h00, pulse, 1'b0, 1'b1);
          end
          ST_INITREG: begin
            panel = ST_INITUI;
            for (int i = 0; i < BURST_LEN; i++) begin
              b = (i == CONTRAST_SLOT) ? contrast_cfg : INIT_SEQ[8*i +: 8];
              push_result(1'b1, b, 1'b0, 1'b0, i == BURST_LEN - 1);
            end
          end
          ST_INITUI: begin
            panel = ST_ON;
            push_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
          end
          ST_GOOFF: begin
            rst_line = 1'b0;
            stamp_ms = now;
            panel = ST_OFF;
            push_result(1'b1, CMD_DISPLAY_OFF, 1'b0, 1'b0, 1'b1);
          end
          ST_OFF: begin
            if (elapsed > {16'd0, off_delay_ms}) panel = ST_IDLE;
            push_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
          end
          default: push_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
        endcase
      end
      MODE_ON_REQ: begin
        if (panel == ST_IDLE) begin
          panel = ST_APPLY;
          push_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
          push_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
        end
      end
      MODE_OFF_REQ: begin
        panel = ST_GOOFF;
        push_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
      end
      MODE_DISPLAY:
        push_result(1'b1, val[0] ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF, 1'b0, 1'b0, 1'b1);
      MODE_CONTRAST: begin
        push_result(1'b1, CMD_SET_CONTRAST, 1'b0, 1'b0, 1'b0);
        push_result(1'b1, val, 1'b0, 1'b0, 1'b1);
      end
      default: push_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
    endcase
  endtask

  // Send one request; open a new burst, possibly after a random gap, when the last one ran out
  task automatic send_req(input logic [2:0] mode, input logic [31:0] now,
                          input logic [7:0] val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (pace_gaps && $urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {val, now};
    do @(posedge clk); while (!in_tready);
    predict_panel(mode, now, val);
    if (mode <= MODE_CONTRAST) requests_sent++;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cmd_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      CFG_START_DELAY: start_delay_ms = data;
      CFG_OFF_DELAY:   off_delay_ms = data;
      default:         contrast_cfg = data[7:0];
    endcase
  endtask

  task automatic set_panel_regs(input logic [15:0] start_ms, input logic [15:0] off_ms,
                                input logic [7:0] contrast);
    wait_all_results();
    write_reg(CFG_START_DELAY, start_ms);
    write_reg(CFG_OFF_DELAY, off_ms);
    write_reg(CFG_CONTRAST, {8'h00, contrast});
  endtask

  // Time step for a wait: hug the delay boundary often
  function automatic logic [31:0] pick_step(input logic [15:0] delay_ms);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 2);
      1:       return {16'd0, delay_ms};
      2:       return {16'd0, delay_ms} + 32'd1;
      default: return $urandom_range(0, delay_ms);
    endcase
  endfunction

  // Stray request that must not disturb the power sequence
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0:       send_req(MODE_DISPLAY, $urandom, 8'($urandom));
      1:       send_req(MODE_CONTRAST, $urandom, 8'($urandom));
      2:       send_req(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), $urandom,
                        8'($urandom));
      default: send_req(MODE_ON_REQ, $urandom, 8'($urandom));
    endcase
  endtask

  // One power-up and power-down with random timing and stray requests
  task automatic power_session();
    int steps;
    pace_gaps = ($urandom_range(0, 3) != 0);
    send_req(MODE_ON_REQ, $urandom, 8'($urandom));
    steps = 0;
    while (panel != ST_IDLE && steps < 80) begin
      steps++;
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else if ((panel == ST_ON && $urandom_range(0, 2) == 0) ||
                   $urandom_range(0, 29) == 0) begin
        send_req(MODE_OFF_REQ, $urandom, 8'($urandom));
      end else begin
        case (panel)
          ST_RESET: ms_now += pick_step(start_delay_ms);
          ST_OFF:   ms_now += pick_step(off_delay_ms);
          default:  ms_now += $urandom_range(0, 3);
        endcase
        send_req(MODE_TICK, ms_now, 8'($urandom));
      end
    end
  endtask

  // Special cases under the reset register values
  task automatic test_reset_defaults();
    logic [31:0] t;
    send_req(MODE_TICK, 32'h0000_0000, 8'h00);
    send_req(MODE_SPARE_LO, 32'h5555_5555, 8'hAA);
    send_req(MODE_SPARE_HI, 32'hFFFF_FFFF, 8'hFF);
    send_req(MODE_DISPLAY, 32'hAAAA_AAAA, 8'h00);
    send_req(MODE_DISPLAY, 32'h1234_5678, 8'hFF);
    send_req(MODE_CONTRAST, 32'h0, 8'h00);
    send_req(MODE_CONTRAST, 32'hFFFF_FFFF, 8'hFF);
    // off from idle, then the off wait across the time wrap
    t = 32'hFFFF_FFF0;
    send_req(MODE_OFF_REQ, t, 8'h00);
    send_req(MODE_TICK, t, 8'h00);
    send_req(MODE_ON_REQ, t, 8'h00);
    send_req(MODE_TICK, t + 32'd100, 8'h00);
    send_req(MODE_TICK, t + 32'd101, 8'h00);
    // power up with the start wait crossing bit 31
    send_req(MODE_ON_REQ, 32'h0, 8'h00);
    send_req(MODE_ON_REQ, 32'h0, 8'h00);
    t = 32'h7FFF_FFFA;
    send_req(MODE_TICK, t, 8'h00);
    send_req(MODE_TICK, t + 32'd10, 8'h00);
    send_req(MODE_TICK, t + 32'd11, 8'h00);
    send_req(MODE_TICK, t + 32'd12, 8'h00);
    send_req(MODE_TICK, t + 32'd13, 8'h00);
    send_req(MODE_DISPLAY, t, 8'h01);
    send_req(MODE_OFF_REQ, t, 8'h00);
    send_req(MODE_OFF_REQ, t, 8'h00);
    t = 32'h0000_8000;
    send_req(MODE_TICK, t, 8'h00);
    send_req(MODE_TICK, t + 32'd101, 8'h00);
    wait_all_results();
  endtask

  // Full sessions at the smallest and largest register settings
  task automatic test_register_extremes();
    set_panel_regs(16'd0, 16'd0, 8'h00);
    ms_now = 32'hFFFF_FFFE;
    repeat (2) power_session();
    set_panel_regs(16'hFFFF, 16'hFFFF, 8'hFF);
    ms_now = 32'hFFFF_0000;
    repeat (2) power_session();
    wait_all_results();
  endtask

  // Random sessions with a fresh register setting every few sessions
  task automatic test_random_sessions();
    int sessions;
    requests_sent = 0;
    sessions = 0;
    ms_now = $urandom;
    while (requests_sent < RANDOM_REQUESTS) begin
      if (sessions % 3 == 0)
        set_panel_regs(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 40)),
                       16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 40)),
                       8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) ms_now = $urandom;
      power_session();
      sessions++;
    end
    wait_all_results();
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val, act_val);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cmd_expect.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = cmd_expect.pop_front();
        check_field("byte_valid", 32'(want.byte_valid), 32'(out_tuser[0]));
        check_field("cmd_byte", 32'(want.cmd), 32'(out_tdata[7:0]));
        check_field("reset_level", 32'(want.rst_level), 32'(out_tdata[OUT_RST_LVL]));
        check_field("reset_pulse", 32'(want.pulse), 32'(out_tdata[OUT_PULSE]));
        check_field("panel_state", 32'(want.state), 32'(out_tdata[OUT_STATE_LO +: 3]));
        check_field("panel_is_on", 32'(want.is_on), 32'(out_tdata[OUT_IS_ON]));
        check_field("panel_is_off", 32'(want.is_off), 32'(out_tdata[OUT_IS_OFF]));
        check_field("request_accepted", 32'(want.accepted), 32'(out_tdata[OUT_ACCEPTED]));
        check_field("keep_awake", 32'(want.awake), 32'(out_tdata[OUT_AWAKE]));
        check_field("tdata padding", 32'd0, 32'(out_tdata[OUT_TDATA_W-1:OUT_AWAKE+1]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  // Receiver stall pattern: always ready, coin flips, or long runs
  int ready_style = 0;
  int style_left = 0;
  int run_left = 0;
  logic run_level = 1'b0;
  always @(posedge clk) begin
    if (style_left == 0) begin
      style_left = $urandom_range(20, 80);
      ready_style = $urandom_range(0, 2);
    end
    style_left--;
    case (ready_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 20);
          run_level = ~run_level;
        end
        run_left--;
        out_tready <= run_level;
      end
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_sessions();
    wait_all_results();
    if (errors == 0 && cmd_expect.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/opis_pkg.sv
rtl/opis_front.sv
rtl/opis_queue.sv
rtl/opis_back.sv
rtl/oled_power_init_sequencer.sv
rtl/opis_checker.sv
tb/testbench.sv
